FILE: design/rtfe_pkg.sv
// Package for the tag frame extractor: default sizes, register reset values
// and configuration register indexes. No dependencies.
`default_nettype none

package rtfe_pkg;

    localparam int FRAME_BYTES_DEF = 24;
    localparam int TAG_OFFSET_DEF  = 8;
    localparam int TAG_BYTES_DEF   = 12;

    localparam int CFG_IDX_W = 2;

    typedef logic [7:0]           t_byte;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_END_MARKER  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_REJECT_TYPE = t_cfg_idx'(1);

    localparam t_byte RESET_END_MARKER  = 8'h7E;
    localparam t_byte RESET_REJECT_TYPE = 8'h01;

endpackage

`default_nettype wire

FILE: design/rtfe_if.sv
// Handshake channels of the tag frame extractor: received bytes, tag bytes
// and configuration writes. Depends on rtfe_pkg.
`default_nettype none

interface rtfe_rx_if;
    logic          valid;
    logic          ready;
    rtfe_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rtfe_tag_if;
    logic            valid;
    logic            ready;
    rtfe_pkg::t_byte tag_byte;
    logic [3:0]      byte_index;
    rtfe_pkg::t_byte tag_sequence;
    logic            last;

    modport source (output valid, output tag_byte, output byte_index,
                    output tag_sequence, output last, input ready);
    modport sink   (input valid, input tag_byte, input byte_index,
                    input tag_sequence, input last, output ready);
endinterface

interface rtfe_cfg_if;
    logic               valid;
    logic               ready;
    rtfe_pkg::t_cfg_idx index;
    rtfe_pkg::t_byte    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/rfid_tag_frame_extractor.sv
// A closing byte that emits a tag loads the tag snapshot register; tag valid is registered.
// Throughput: one received byte per cycle; a closing byte that emits a tag starts
// a burst of TAG_BYTES requests, one per cycle unless the receiver stalls, and the
// next byte waits until the final tag byte is taken (the single tag snapshot
// register sets this). Reset (synchronous, active low) clears the frame store,
// position, sequence number and burst state, and loads the register reset values.
`default_nettype none

module rfid_tag_frame_extractor #(
    parameter int FRAME_BYTES = rtfe_pkg::FRAME_BYTES_DEF,
    parameter int TAG_OFFSET  = rtfe_pkg::TAG_OFFSET_DEF,
    parameter int TAG_BYTES   = rtfe_pkg::TAG_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rtfe_rx_if.sink     i_rx,
    rtfe_cfg_if.sink    i_cfg,
    rtfe_tag_if.source  o_tag
);
    import rtfe_pkg::*;

    localparam int PW    = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;

    t_byte            r_end_marker;
    t_byte            r_reject_type;
    logic [PW-1:0]    r_pos,  n_pos;
    t_byte            r_store [FRAME_BYTES];
    t_byte            r_seq;
    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_idx;
    t_byte            r_tag  [TAG_BYTES];
    t_byte            w_snap [TAG_BYTES];

    logic  rx_acc, tag_acc, tag_done, stores, closes, emit;
    t_byte rx_b, type_byte;

    assign rx_b     = i_rx.rx_byte;
    assign tag_done = tag_acc && o_tag.last;
    assign i_rx.ready = !r_busy || tag_done;
    assign rx_acc   = i_rx.valid && i_rx.ready;
    assign tag_acc  = o_tag.valid && o_tag.ready;
    assign stores   = (r_pos < PW'(FRAME_BYTES));
    assign closes   = (rx_b == r_end_marker);

    // Byte 1 as it stands after this byte has been stored.
    assign type_byte = (r_pos == PW'(1)) ? rx_b : r_store[1];
    assign emit      = rx_acc && closes && (type_byte != r_reject_type);

    // Tag bytes as the store holds them once this byte is written.
    for (genvar k = 0; k < TAG_BYTES; k++) begin : g_snap
        if (TAG_OFFSET + k < FRAME_BYTES) begin : g_in
            assign w_snap[k] = (r_pos == PW'(TAG_OFFSET + k)) ? rx_b
                                                             : r_store[TAG_OFFSET + k];
        end else begin : g_out
            assign w_snap[k] = '0;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (rx_acc) begin
            if (closes) begin
                n_pos = '0;
            end else if (stores) begin
                n_pos = r_pos + PW'(1);
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (emit) begin
            n_busy = 1'b1;
        end else if (tag_done) begin
            n_busy = 1'b0;
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_marker  <= RESET_END_MARKER;
            r_reject_type <= RESET_REJECT_TYPE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_END_MARKER:  r_end_marker  <= i_cfg.data;
                CFG_REJECT_TYPE: r_reject_type <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_busy <= 1'b0;
            r_seq  <= '0;
            r_idx  <= '0;
            for (int j = 0; j < FRAME_BYTES; j++) begin
                r_store[j] <= '0;
            end
        end else begin
            r_pos  <= n_pos;
            r_busy <= n_busy;
            if (rx_acc && stores) begin
                r_store[r_pos[PW-1:0]] <= rx_b;
            end
            if (emit) begin
                r_seq <= r_seq + 8'd1;
                r_idx <= '0;
            end else if (tag_acc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Tag snapshot: loaded on a closing byte that emits a tag, shifted down as bytes are taken.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            for (int k = 0; k < TAG_BYTES; k++) begin
                r_tag[k] <= w_snap[k];
            end
        end else if (tag_acc) begin
            for (int k = 0; k < TAG_BYTES - 1; k++) begin
                r_tag[k] <= r_tag[k + 1];
            end
        end
    end

    t_byte r_out_seq;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_seq <= r_seq;
        end
    end

    assign o_tag.valid        = r_busy;
    assign o_tag.tag_byte     = r_tag[0];
    assign o_tag.byte_index   = 4'(r_idx);
    assign o_tag.tag_sequence = r_out_seq;
    assign o_tag.last         = (r_idx == IDX_W'(TAG_BYTES - 1));

endmodule

`default_nettype wire

FILE: design/rtfe_chk.sv
// Port-level checks for the tag frame extractor, attached to the top level by
// the bind statement below. Depends on rfid_tag_frame_extractor.
`default_nettype none

module rtfe_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_tag_valid,
    input wire       i_tag_ready,
    input wire [7:0] i_tag_byte,
    input wire [3:0] i_byte_index,
    input wire [7:0] i_tag_sequence,
    input wire       i_tag_last
);

    // A stalled request keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tag_valid && !i_tag_ready |=> i_tag_valid && $stable(i_tag_byte)
            && $stable(i_byte_index) && $stable(i_tag_sequence) && $stable(i_tag_last))
        else $error("tag request changed while stalled");

    // Within a burst the byte index counts up by one.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tag_valid && i_tag_ready && !i_tag_last |=>
            i_tag_valid && i_byte_index == 4'($past(i_byte_index) + 4'd1))
        else $error("tag burst broken or index skipped");

    // A burst keeps one sequence number.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tag_valid && i_tag_ready && !i_tag_last |=>
            i_tag_sequence == $past(i_tag_sequence))
        else $error("sequence number changed inside a burst");

    // A new burst after a final byte starts at index zero.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tag_valid && i_tag_ready && i_tag_last |=> !i_tag_valid || i_byte_index == 4'd0)
        else $error("burst did not start at index zero");

endmodule

bind rfid_tag_frame_extractor rtfe_chk u_rtfe_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_tag_valid    (o_tag.valid),
    .i_tag_ready    (o_tag.ready),
    .i_tag_byte     (o_tag.tag_byte),
    .i_byte_index   (o_tag.byte_index),
    .i_tag_sequence (o_tag.tag_sequence),
    .i_tag_last     (o_tag.last)
);

`default_nettype wire

FILE: dv/rfid_tag_frame_extractor_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rfid_tag_frame_extractor: random and directed reader frames,
// with its own prediction of the tag bytes each frame end emits.
// Depends on rtfe_pkg, the rtfe_*_if interfaces and the extractor itself.

module rfid_tag_frame_extractor_test;
    import rtfe_pkg::*;

    localparam int FRAME_BYTES = FRAME_BYTES_DEF;
    localparam int TAG_OFFSET  = TAG_OFFSET_DEF;
    localparam int TAG_BYTES   = TAG_BYTES_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 4;
    localparam int GAP_PCT     = 26;

    // Indexes the block does not decode; writes to them must change nothing.
    localparam t_cfg_idx CFG_SPARE_LO = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_SPARE_HI = t_cfg_idx'(3);

    typedef struct packed {
        t_byte      tag_byte;
        logic [3:0] byte_index;
        t_byte      tag_sequence;
        logic       last;
    } t_tag_beat;

    logic clk;
    logic rst_n;

    rtfe_rx_if  rx_ch();
    rtfe_cfg_if cfg_ch();
    rtfe_tag_if tag_ch();

    rfid_tag_frame_extractor DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_tag   (tag_ch)
    );

    // Predicted state of the extractor.
    int         frame_pos;
    t_byte      frame_mem [FRAME_BYTES];
    t_byte      tag_seq;
    t_byte      end_marker_reg;
    t_byte      reject_type_reg;
    t_tag_beat  expected_tags [$];
    int         err_count;

    bit rx_gaps_on;
    bit tag_gaps_on;
    int hold_len;
    int hold_req;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic t_byte stored_at(int pos);
        return (pos < FRAME_BYTES) ? frame_mem[pos] : 8'h00;
    endfunction

    function automatic void clear_prediction();
        frame_pos       = 0;
        tag_seq         = '0;
        end_marker_reg  = RESET_END_MARKER;
        reject_type_reg = RESET_REJECT_TYPE;
        for (int i = 0; i < FRAME_BYTES; i++) frame_mem[i] = '0;
        expected_tags.delete();
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, t_byte data);
        case (idx)
            CFG_END_MARKER:  end_marker_reg  = data;
            CFG_REJECT_TYPE: reject_type_reg = data;
            default: ;
        endcase
    endfunction

    // Stores the byte, and on the end marker queues the tag bytes unless the
    // frame type says no tag was read.
    function automatic void absorb_byte(t_byte b);
        t_tag_beat beat;
        if (frame_pos < FRAME_BYTES) begin
            frame_mem[frame_pos] = b;
            frame_pos++;
        end
        if (b == end_marker_reg) begin
            if (stored_at(1) != reject_type_reg) begin
                for (int k = 0; k < TAG_BYTES; k++) begin
                    beat.tag_byte     = stored_at(TAG_OFFSET + k);
                    beat.byte_index   = 4'(k);
                    beat.tag_sequence = tag_seq;
                    beat.last         = (k == TAG_BYTES - 1);
                    expected_tags.push_back(beat);
                end
                tag_seq++;
            end
            frame_pos = 0;
        end
    endfunction

    // Checking comes before prediction so that ordering within the edge never matters.
    always @(posedge clk) begin : scoreboard
        t_tag_beat want;
        if (!rst_n) begin
            clear_prediction();
        end else begin
            if (tag_ch.valid && tag_ch.ready) begin
                if (expected_tags.size() == 0) begin
                    $error("unexpected tag byte %0h at index %0d", tag_ch.tag_byte,
                           tag_ch.byte_index);
                    err_count++;
                end else begin
                    want = expected_tags.pop_front();
                    if (tag_ch.tag_byte !== want.tag_byte) begin
                        $error("tag_byte: expected %0h, actual %0h", want.tag_byte,
                               tag_ch.tag_byte);
                        err_count++;
                    end
                    if (tag_ch.byte_index !== want.byte_index) begin
                        $error("byte_index: expected %0d, actual %0d", want.byte_index,
                               tag_ch.byte_index);
                        err_count++;
                    end
                    if (tag_ch.tag_sequence !== want.tag_sequence) begin
                        $error("tag_sequence: expected %0d, actual %0d",
                               want.tag_sequence, tag_ch.tag_sequence);
                        err_count++;
                    end
                    if (tag_ch.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, tag_ch.last);
                        err_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
            if (rx_ch.valid && rx_ch.ready) absorb_byte(rx_ch.rx_byte);
        end
    end

    always @(posedge clk) begin : watchdog
        int quiet;
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (tag_ch.valid && tag_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Tag receiver: random back-pressure, plus long holds requested by the tests.
    initial begin : tag_receiver
        int hold_left;
        int hold_ack;
        hold_left    = 0;
        hold_ack     = 0;
        tag_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                tag_ch.ready <= 1'b0;
            end else begin
                tag_ch.ready <= !(tag_gaps_on && $urandom_range(0, 99) < GAP_PCT);
            end
        end
    end

    function automatic t_byte body_byte();
        t_byte b;
        do b = t_byte'($urandom); while (b == end_marker_reg);
        return b;
    endfunction

    function automatic t_byte tag_type_byte();
        t_byte b;
        do b = t_byte'($urandom);
        while (b == end_marker_reg || b == reject_type_reg);
        return b;
    endfunction

    // Offers one received byte and returns at the edge that takes it; valid
    // stays up until the next falling edge.
    task automatic send_byte(t_byte b);
        @(negedge clk);
        while (rx_gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (expected_tags.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_byte data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(t_byte marker, t_byte reject);
        wait_drained();
        write_reg(CFG_END_MARKER, marker);
        write_reg(CFG_REJECT_TYPE, reject);
    endtask

    // Body bytes then the end marker; the type byte decides whether a tag comes out.
    task automatic send_frame(int body_len, bit rejected);
        t_byte b;
        for (int i = 0; i < body_len; i++) begin
            if (i == 1) b = rejected ? reject_type_reg : tag_type_byte();
            else        b = body_byte();
            send_byte(b);
        end
        send_byte(end_marker_reg);
    endtask

    // Mostly well-formed frames, with short ones, overflowing ones and loose noise.
    task automatic random_frames(int target);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
                if (pick < 60)      len = $urandom_range(18, FRAME_BYTES);
                else if (pick < 75) len = $urandom_range(0, 3);
                else                len = $urandom_range(FRAME_BYTES + 1, 40);
                send_frame(len, $urandom_range(0, 99) < 25);
                sent += len + 1;
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) send_byte(t_byte'($urandom));
                sent += len;
            end
        end
    endtask

    // A lone marker straight after reset reads the cleared type byte and emits zeros.
    task automatic test_short_frame_after_reset();
        send_byte(end_marker_reg);
        wait_drained();
    endtask

    // Walking ones and zeros through a frame of 20 body bytes, so every input bit toggles.
    task automatic test_full_frame();
        t_byte b;
        for (int i = 0; i < 20; i++) begin
            b = 8'h01 << ((i / 2) % 8);
            if (i[0]) b = ~b;
            send_byte(b);
        end
        send_byte(end_marker_reg);
        wait_drained();
    endtask

    task automatic test_rejected_frame();
        send_byte(8'h00);
        send_byte(reject_type_reg);
        send_byte(end_marker_reg);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        set_config(8'h00, 8'hFF);
        write_reg(CFG_SPARE_LO, 8'hFF);
        write_reg(CFG_SPARE_HI, 8'h00);
        random_frames(50);
        set_config(8'hFF, 8'h00);
        write_reg(CFG_SPARE_LO, 8'h00);
        write_reg(CFG_SPARE_HI, 8'hFF);
        random_frames(50);
    endtask

    // The receiver holds off while frames keep arriving, so the block must stall
    // its input behind the pending tag burst.
    task automatic test_receiver_hold();
        set_config(t_byte'($urandom), t_byte'($urandom));
        hold_len = 200;
        hold_req++;
        for (int i = 0; i < 3; i++) send_frame(22, 1'b0);
        wait_drained();
    endtask

    task automatic test_no_idle_stretch();
        rx_gaps_on  = 1'b0;
        tag_gaps_on = 1'b0;
        random_frames(50);
        wait_drained();
        rx_gaps_on  = 1'b1;
        tag_gaps_on = 1'b1;
    endtask

    task automatic test_reset_values_restored();
        set_config(RESET_END_MARKER, RESET_REJECT_TYPE);
        random_frames(40);
    endtask

    initial begin
        err_count      = 0;
        hold_len       = 0;
        hold_req       = 0;
        rx_gaps_on     = 1'b1;
        tag_gaps_on    = 1'b1;
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_END_MARKER;
        cfg_ch.data    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_short_frame_after_reset();
        test_full_frame();
        test_rejected_frame();
        random_frames(80);
        test_config_extremes();
        test_receiver_hold();
        test_no_idle_stretch();
        test_reset_values_restored();

        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
design/rtfe_pkg.sv
design/rtfe_if.sv
design/rfid_tag_frame_extractor.sv
design/rtfe_chk.sv
dv/rfid_tag_frame_extractor_test.sv
